// File: rtl/core/sdne_pkg.sv
// ----------------------------------------------------------------------------
// sdne_pkg: shared types and constants of the scaled decimal number encoder
// Payload structs, sequencer controls, byte kinds and encoding constants.
// ----------------------------------------------------------------------------
package sdne_pkg;

  // Magnitude width that the conversion honors; 64 drops the upper half
  localparam int MAG_BITS           = 128;
  localparam int MAX_MANTISSA_PAIRS = 20;

  // Conversion runs over both 64-bit halves, one bit a cycle
  localparam int CONV_STEPS = 128;
  localparam int CNT_W      = $clog2(CONV_STEPS);

  // Base-100 pairs held in the BCD register (39 digits plus alignment fit)
  localparam int NUM_PAIRS = 22;
  localparam int BCD_W     = 8 * NUM_PAIRS;
  localparam int PIDX_W    = $clog2(NUM_PAIRS + 1);

  // Encoding constants
  localparam logic [7:0] BYTE_ZERO     = 8'h80;
  localparam logic [7:0] EXP_POS_BIAS  = 8'hC1;
  localparam logic [7:0] EXP_NEG_BIAS  = 8'h3E;
  localparam logic [7:0] NEG_MANT_BASE = 8'd101;
  localparam logic [7:0] TERM_BYTE     = 8'd102;

  typedef struct packed {
    logic [63:0] magnitude_hi;
    logic [63:0] magnitude_lo;
    logic        negative;
    logic [5:0]  scale;
  } num_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       too_long;
  } enc_t;

  typedef enum logic [2:0] {
    KIND_ZERO,
    KIND_ERR,
    KIND_EXP,
    KIND_MANT,
    KIND_TERM
  } byte_kind_t;

  // Commands from the sequencer to the BCD register
  typedef struct packed {
    logic load;
    logic step;
    logic digit_shift;
    logic rotate;
  } conv_ctrl_t;

  // Request to load the next byte into the output register
  typedef struct packed {
    logic       push;
    byte_kind_t kind;
    logic       last;
  } fmt_req_t;

  // Value 0..99 of one packed BCD digit pair
  function automatic logic [6:0] pair_value(input logic [7:0] bcd);
    logic [6:0] tens;
    logic [6:0] ones;
    tens = {3'b000, bcd[7:4]};
    ones = {3'b000, bcd[3:0]};
    return (tens << 3) + (tens << 1) + ones;
  endfunction

endpackage

// File: rtl/core/sdne_bcd_conv.sv
// ----------------------------------------------------------------------------
// sdne_bcd_conv: bit-serial binary to BCD conversion register
// Shifts the magnitude in one bit a cycle with add-3 digit correction, then
// aligns by one digit and rotates pair by pair for scanning and output.
// ----------------------------------------------------------------------------
module sdne_bcd_conv (
  input  logic                 clk,
  input  sdne_pkg::conv_ctrl_t ctrl,
  input  logic [63:0]          magnitude_hi,
  input  logic [63:0]          magnitude_lo,
  output logic [7:0]           top_pair
);

  localparam logic HI_USED = (sdne_pkg::MAG_BITS > 64);

  logic [127:0]               bin;
  logic [sdne_pkg::BCD_W-1:0] bcd;
  logic [sdne_pkg::BCD_W-1:0] bcd_adj;

  // Correct every digit of 5 or more before the doubling shift
  always_comb begin
    for (int d = 0; d < 2 * sdne_pkg::NUM_PAIRS; d++) begin
      bcd_adj[4*d +: 4] = (bcd[4*d +: 4] >= 4'd5) ? bcd[4*d +: 4] + 4'd3 : bcd[4*d +: 4];
    end
  end

  // Load, convert, align and rotate
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin <= {magnitude_hi & {64{HI_USED}}, magnitude_lo};
      bcd <= '0;
    end else if (ctrl.step) begin
      bin <= {bin[126:0], 1'b0};
      bcd <= {bcd_adj[sdne_pkg::BCD_W-2:0], bin[127]};
    end else if (ctrl.digit_shift) begin
      bcd <= {bcd[sdne_pkg::BCD_W-5:0], 4'h0};
    end else if (ctrl.rotate) begin
      bcd <= {bcd[sdne_pkg::BCD_W-9:0], bcd[sdne_pkg::BCD_W-1 -: 8]};
    end
  end

  assign top_pair = bcd[sdne_pkg::BCD_W-1 -: 8];

endmodule

// File: rtl/core/sdne_out_stage.sv
// ----------------------------------------------------------------------------
// sdne_out_stage: byte formatting and output register
// Forms the exponent, mantissa, terminator, zero or error byte and holds it
// until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module sdne_out_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  sdne_pkg::fmt_req_t         req,
  input  logic                       negative,
  input  logic [sdne_pkg::PIDX_W-1:0] top,
  input  logic [5:0]                 half_scale,
  input  logic [7:0]                 pair_bcd,
  output logic                       free,
  output logic                       enc_valid,
  input  logic                       enc_ready,
  output sdne_pkg::enc_t             enc
);

  logic [7:0]     expo;
  logic [7:0]     pair;
  sdne_pkg::enc_t enc_next;

  // Exponent wraps modulo 256
  assign expo = 8'(top) - 8'd1 - {2'b00, half_scale};
  assign pair = {1'b0, sdne_pkg::pair_value(pair_bcd)};
  assign free = !enc_valid || enc_ready;

  // Select the byte for this request
  always_comb begin
    enc_next.last     = req.last;
    enc_next.too_long = 1'b0;
    case (req.kind)
      sdne_pkg::KIND_ZERO: enc_next.out_byte = sdne_pkg::BYTE_ZERO;
      sdne_pkg::KIND_ERR: begin
        enc_next.out_byte = 8'd0;
        enc_next.too_long = 1'b1;
      end
      sdne_pkg::KIND_EXP:
        enc_next.out_byte = negative ? sdne_pkg::EXP_NEG_BIAS - expo
                                     : sdne_pkg::EXP_POS_BIAS + expo;
      sdne_pkg::KIND_MANT:
        enc_next.out_byte = negative ? sdne_pkg::NEG_MANT_BASE - pair : pair + 8'd1;
      sdne_pkg::KIND_TERM: enc_next.out_byte = sdne_pkg::TERM_BYTE;
      default:             enc_next.out_byte = 8'd0;
    endcase
  end

  // Hold the byte until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      enc_valid <= 1'b0;
    end else if (req.push) begin
      enc_valid <= 1'b1;
    end else if (enc_ready) begin
      enc_valid <= 1'b0;
    end
    if (req.push) begin
      enc <= enc_next;
    end
  end

endmodule

// File: rtl/core/scaled_decimal_number_encoder.sv
// ----------------------------------------------------------------------------
// scaled_decimal_number_encoder: base-100 variable-length number encoder
// Converts a signed, scaled 128-bit magnitude to an exponent byte and
// base-100 mantissa bytes, trimming zero pairs at both ends.
// ----------------------------------------------------------------------------
// Sequence: bit-serial conversion (one magnitude bit each), a digit-align
// step, a scan of all 22 pairs, alignment by up to 21 rotates, then one byte
// per cycle (1 to 21 bytes) while the output register is free; an output
// stall holds the sequencer until the byte is taken.
// Throughput: one item at a time, taken again once the last byte is loaded;
// the bit-serial BCD register sets the pace. Reset: sequencer and valid clear.
// ----------------------------------------------------------------------------
module scaled_decimal_number_encoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           num_valid,
  output logic           num_ready,
  input  sdne_pkg::num_t num,
  output logic           enc_valid,
  input  logic           enc_ready,
  output sdne_pkg::enc_t enc
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_DIGIT,
    S_SCAN,
    S_ALIGN,
    S_HEAD,
    S_MANT,
    S_TERM
  } state_t;

  state_t                      state;
  logic [sdne_pkg::CNT_W-1:0]  cnt;
  logic                        negative;
  logic                        odd;
  logic [5:0]                  half_scale;
  logic [sdne_pkg::PIDX_W-1:0] top;
  logic [sdne_pkg::PIDX_W-1:0] bot;
  logic                        found;
  logic [sdne_pkg::PIDX_W-1:0] rem;

  sdne_pkg::conv_ctrl_t        ctrl;
  sdne_pkg::fmt_req_t          req;
  logic [7:0]                  top_pair;
  logic                        free;
  logic                        accept;
  logic [sdne_pkg::PIDX_W-1:0] scan_idx;
  logic [sdne_pkg::PIDX_W-1:0] align_need;
  logic                        align_more;
  logic [sdne_pkg::PIDX_W-1:0] mant;
  logic                        is_zero;
  logic                        is_long;
  logic                        term_needed;
  logic [6:0]                  scale_up;

  assign num_ready   = (state == S_IDLE);
  assign accept      = num_valid && num_ready;
  assign scan_idx    = sdne_pkg::PIDX_W'(sdne_pkg::NUM_PAIRS - 1)
                       - cnt[sdne_pkg::PIDX_W-1:0];
  assign align_need  = sdne_pkg::PIDX_W'(sdne_pkg::NUM_PAIRS) - top;
  assign align_more  = (top != '0) && (cnt[sdne_pkg::PIDX_W-1:0] != align_need);
  assign mant        = top - bot;
  assign is_zero     = (top == '0);
  assign is_long     = (mant > sdne_pkg::PIDX_W'(sdne_pkg::MAX_MANTISSA_PAIRS));
  assign term_needed = negative && (mant < sdne_pkg::PIDX_W'(sdne_pkg::MAX_MANTISSA_PAIRS));
  assign scale_up    = {1'b0, num.scale} + 7'd1;

  // Drive the BCD register commands
  always_comb begin
    ctrl.load        = accept;
    ctrl.step        = (state == S_CONV);
    ctrl.digit_shift = (state == S_DIGIT) && odd;
    ctrl.rotate      = (state == S_SCAN) || ((state == S_ALIGN) && align_more)
                       || ((state == S_MANT) && free);
  end

  // Request output bytes
  always_comb begin
    req.push = 1'b0;
    req.kind = sdne_pkg::KIND_EXP;
    req.last = 1'b0;
    case (state)
      S_HEAD: begin
        req.push = free;
        if (is_zero) begin
          req.kind = sdne_pkg::KIND_ZERO;
          req.last = 1'b1;
        end else if (is_long) begin
          req.kind = sdne_pkg::KIND_ERR;
          req.last = 1'b1;
        end
      end
      S_MANT: begin
        req.push = free;
        req.kind = sdne_pkg::KIND_MANT;
        req.last = (rem == sdne_pkg::PIDX_W'(1)) && !term_needed;
      end
      S_TERM: begin
        req.push = free;
        req.kind = sdne_pkg::KIND_TERM;
        req.last = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequence conversion, scan, alignment and output
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      found <= 1'b0;
      top   <= '0;
      bot   <= '0;
      rem   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            negative   <= num.negative;
            odd        <= num.scale[0];
            half_scale <= scale_up[6:1];
            cnt        <= '0;
            found      <= 1'b0;
            top        <= '0;
            bot        <= '0;
            state      <= S_CONV;
          end
        end
        S_CONV: begin
          cnt <= cnt + 1'b1;
          if (cnt == sdne_pkg::CNT_W'(sdne_pkg::CONV_STEPS - 1)) begin
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          cnt   <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // Highest nonzero pair sets top, lowest sets bot
          if (top_pair != 8'd0) begin
            if (!found) begin
              top   <= scan_idx + 1'b1;
              found <= 1'b1;
            end
            bot <= scan_idx;
          end
          if (cnt == sdne_pkg::CNT_W'(sdne_pkg::NUM_PAIRS - 1)) begin
            cnt   <= '0;
            state <= S_ALIGN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ALIGN: begin
          if (align_more) begin
            cnt <= cnt + 1'b1;
          end else begin
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (free) begin
            rem   <= mant;
            state <= (is_zero || is_long) ? S_IDLE : S_MANT;
          end
        end
        S_MANT: begin
          if (free) begin
            rem <= rem - 1'b1;
            if (rem == sdne_pkg::PIDX_W'(1)) begin
              state <= term_needed ? S_TERM : S_IDLE;
            end
          end
        end
        S_TERM: begin
          if (free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  sdne_bcd_conv u_conv (
    .clk          (clk),
    .ctrl         (ctrl),
    .magnitude_hi (num.magnitude_hi),
    .magnitude_lo (num.magnitude_lo),
    .top_pair     (top_pair)
  );

  sdne_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .negative   (negative),
    .top        (top),
    .half_scale (half_scale),
    .pair_bcd   (top_pair),
    .free       (free),
    .enc_valid  (enc_valid),
    .enc_ready  (enc_ready),
    .enc        (enc)
  );

endmodule
